>>> src/aoq_pkg.sv
// Shared constants and types of the arrival-ordered job queue.
package aoq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

>>> src/aoq_ctrl.sv
// Controller state machine that sequences beat capture, execution and result handoff.
module aoq_ctrl import aoq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.execute = w_out_free;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_exec_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> r_out_valid)
        else $error("output register not loaded after execution");

endmodule

>>> src/aoq_datapath.sv
// Datapath holding the sorted slot registers with parallel compare-and-shift and the result register.
module aoq_datapath import aoq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_op,
    input  logic [31:0] i_arrival,
    input  logic [15:0] i_serve_time,
    input  logic [7:0]  i_job_name,
    input  logic [7:0]  i_job_kind,
    output logic [1:0]  o_status,
    output logic [4:0]  o_occupancy,
    output logic [31:0] o_out_arrival,
    output logic [15:0] o_out_serve_time,
    output logic [7:0]  o_out_name,
    output logic [7:0]  o_out_kind
);

    t_op         r_op;
    logic [31:0] r_arr;
    logic [15:0] r_srv;
    logic [7:0]  r_name;
    logic [7:0]  r_kind;

    logic [31:0] r_slot_arr  [DEPTH];
    logic [15:0] r_slot_srv  [DEPTH];
    logic [7:0]  r_slot_name [DEPTH];
    logic [7:0]  r_slot_kind [DEPTH];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic [DEPTH-1:0] w_le;
    logic             w_full;
    logic             w_empty;
    logic             w_ins;
    logic             w_del;
    t_status          n_status;

    t_status          r_status;
    logic [CNT_W-1:0] r_occ;
    logic [31:0]      r_out_arr;
    logic [15:0]      r_out_srv;
    logic [7:0]       r_out_name;
    logic [7:0]       r_out_kind;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_op);
            r_arr  <= i_arrival;
            r_srv  <= i_serve_time;
            r_name <= i_job_name;
            r_kind <= i_job_kind;
        end
    end

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_ins   = i_cmd.execute && (r_op == OP_ENQ) && !w_full;
    assign w_del   = i_cmd.execute && (r_op == OP_DEQ) && !w_empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_slot
        assign w_le[g] = (r_count > CNT_W'(g)) && (r_slot_arr[g] <= r_arr);

        logic w_take_new;
        if (g == 0) begin : g_head
            assign w_take_new = 1'b1;
        end else begin : g_body
            assign w_take_new = w_le[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (w_ins && !w_le[g]) begin
                if (w_take_new) begin
                    r_slot_arr[g]  <= r_arr;
                    r_slot_srv[g]  <= r_srv;
                    r_slot_name[g] <= r_name;
                    r_slot_kind[g] <= r_kind;
                end else begin
                    r_slot_arr[g]  <= r_slot_arr[(g == 0) ? 0 : g-1];
                    r_slot_srv[g]  <= r_slot_srv[(g == 0) ? 0 : g-1];
                    r_slot_name[g] <= r_slot_name[(g == 0) ? 0 : g-1];
                    r_slot_kind[g] <= r_slot_kind[(g == 0) ? 0 : g-1];
                end
            end else if (w_del && (g < DEPTH - 1)) begin
                r_slot_arr[g]  <= r_slot_arr[(g < DEPTH - 1) ? g+1 : g];
                r_slot_srv[g]  <= r_slot_srv[(g < DEPTH - 1) ? g+1 : g];
                r_slot_name[g] <= r_slot_name[(g < DEPTH - 1) ? g+1 : g];
                r_slot_kind[g] <= r_slot_kind[(g < DEPTH - 1) ? g+1 : g];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del) begin
            n_count = r_count - CNT_W'(1);
        end
        case (r_op)
            OP_ENQ:  n_status = w_full ? ST_FULL : ST_ENQ;
            OP_DEQ:  n_status = w_empty ? ST_EMPTY : ST_DEQ;
            default: n_status = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status <= n_status;
            r_occ    <= n_count;
            if (w_del) begin
                r_out_arr  <= r_slot_arr[0];
                r_out_srv  <= r_slot_srv[0];
                r_out_name <= r_slot_name[0];
                r_out_kind <= r_slot_kind[0];
            end else begin
                r_out_arr  <= '0;
                r_out_srv  <= '0;
                r_out_name <= '0;
                r_out_kind <= '0;
            end
        end
    end

    assign o_status         = r_status;
    assign o_occupancy      = 5'(r_occ);
    assign o_out_arrival    = r_out_arr;
    assign o_out_serve_time = r_out_srv;
    assign o_out_name       = r_out_name;
    assign o_out_kind       = r_out_kind;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy exceeds depth");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not raise occupancy by one");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) |-> r_slot_arr[0] <= r_slot_arr[1])
        else $error("head slots out of arrival order");

endmodule

>>> src/arrival_ordered_job_queue.sv
// A beat is captured, executed once the output register is free, and its result is valid in the cycle after execution.
// The capture/execute sequence of the controller takes a new beat only after the last one has executed.
// An insert or remove touches all slots at once through a parallel compare-and-shift.
// Reset: synchronous, active low; the queue is empty afterwards and slot contents are undefined.
// The input stalls while a beat executes, and execution waits while the last result is stalled.
module arrival_ordered_job_queue import aoq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [31:0] i_arrival,
    input  logic [15:0] i_serve_time,
    input  logic [7:0]  i_job_name,
    input  logic [7:0]  i_job_kind,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [4:0]  o_occupancy,
    output logic [31:0] o_out_arrival,
    output logic [15:0] o_out_serve_time,
    output logic [7:0]  o_out_name,
    output logic [7:0]  o_out_kind
);

    t_cmd w_cmd;

    aoq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    aoq_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_op             (i_op),
        .i_arrival        (i_arrival),
        .i_serve_time     (i_serve_time),
        .i_job_name       (i_job_name),
        .i_job_kind       (i_job_kind),
        .o_status         (o_status),
        .o_occupancy      (o_occupancy),
        .o_out_arrival    (o_out_arrival),
        .o_out_serve_time (o_out_serve_time),
        .o_out_name       (o_out_name),
        .o_out_kind       (o_out_kind)
    );

endmodule
